[rtl/core/bpf_pkg.sv]
// Shared types, opcode constants and the fusion pair table for bytecode pair fusion.
`default_nettype none
package bpf_pkg;

   localparam int WORD_W              = 64;
   localparam int OP_W                = 6;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [2:0] KIND_EXTRA = 3'd0;
   localparam logic [2:0] KIND_ONE   = 3'd1;
   localparam logic [2:0] KIND_TWO   = 3'd2;
   localparam logic [2:0] KIND_FOUR  = 3'd4;
   localparam logic [2:0] KIND_EMPTY = 3'd7;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_END = 1'b1;

   localparam logic [OP_W-1:0] OP_PUSH                 = 6'd0;
   localparam logic [OP_W-1:0] OP_CONSTANT             = 6'd1;
   localparam logic [OP_W-1:0] OP_REFER_LOCAL          = 6'd2;
   localparam logic [OP_W-1:0] OP_REFER_GLOBAL         = 6'd3;
   localparam logic [OP_W-1:0] OP_REFER_FREE           = 6'd4;
   localparam logic [OP_W-1:0] OP_NUMBER_ADD           = 6'd5;
   localparam logic [OP_W-1:0] OP_NUMBER_SUB           = 6'd6;
   localparam logic [OP_W-1:0] OP_CAR                  = 6'd7;
   localparam logic [OP_W-1:0] OP_CDR                  = 6'd8;
   localparam logic [OP_W-1:0] OP_NOT                  = 6'd9;
   localparam logic [OP_W-1:0] OP_TEST                 = 6'd10;
   localparam logic [OP_W-1:0] OP_BR_NOT_NULL          = 6'd11;
   localparam logic [OP_W-1:0] OP_BR_NOT_LT            = 6'd12;
   localparam logic [OP_W-1:0] OP_BR_NOT_LE            = 6'd13;
   localparam logic [OP_W-1:0] OP_BR_NOT_NUM_EQ        = 6'd14;
   localparam logic [OP_W-1:0] OP_BR_NOT_GE            = 6'd15;
   localparam logic [OP_W-1:0] OP_FRAME                = 6'd16;
   localparam logic [OP_W-1:0] OP_ENTER                = 6'd17;
   localparam logic [OP_W-1:0] OP_CALL                 = 6'd18;
   localparam logic [OP_W-1:0] OP_SHIFT                = 6'd19;
   localparam logic [OP_W-1:0] OP_NUMBER_ADD_PUSH      = 6'd20;
   localparam logic [OP_W-1:0] OP_NUMBER_SUB_PUSH      = 6'd21;
   localparam logic [OP_W-1:0] OP_CAR_PUSH             = 6'd22;
   localparam logic [OP_W-1:0] OP_CDR_PUSH             = 6'd23;
   localparam logic [OP_W-1:0] OP_CONSTANT_PUSH        = 6'd24;
   localparam logic [OP_W-1:0] OP_REFER_LOCAL_PUSH     = 6'd25;
   localparam logic [OP_W-1:0] OP_REFER_GLOBAL_PUSH    = 6'd26;
   localparam logic [OP_W-1:0] OP_REFER_FREE_PUSH      = 6'd27;
   localparam logic [OP_W-1:0] OP_NOT_TEST             = 6'd28;
   localparam logic [OP_W-1:0] OP_RL_BR_NOT_NULL       = 6'd29;
   localparam logic [OP_W-1:0] OP_RL_BR_NOT_LT         = 6'd30;
   localparam logic [OP_W-1:0] OP_RL_PUSH_CONSTANT     = 6'd31;
   localparam logic [OP_W-1:0] OP_RLPC_BR_NOT_LE       = 6'd32;
   localparam logic [OP_W-1:0] OP_RLPC_BR_NOT_NUM_EQ   = 6'd33;
   localparam logic [OP_W-1:0] OP_RLPC_BR_NOT_GE       = 6'd34;
   localparam logic [OP_W-1:0] OP_PUSH_FRAME           = 6'd35;
   localparam logic [OP_W-1:0] OP_PUSH_ENTER           = 6'd36;
   localparam logic [OP_W-1:0] OP_PUSH_CONSTANT        = 6'd37;
   localparam logic [OP_W-1:0] OP_REFER_GLOBAL_CALL    = 6'd38;
   localparam logic [OP_W-1:0] OP_REFER_LOCAL_CALL     = 6'd39;
   localparam logic [OP_W-1:0] OP_REFER_FREE_CALL      = 6'd40;
   localparam logic [OP_W-1:0] OP_SHIFT_CALL           = 6'd41;

   typedef struct packed {
      logic              cmd;
      logic [2:0]        kind;
      logic [WORD_W-1:0] instr_word;
      logic [WORD_W-1:0] arg_one;
      logic [WORD_W-1:0] arg_two;
      logic [WORD_W-1:0] arg_three;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] code_word;
      logic              last_word;
   } rsp_payload_type;

   // One drained packet on its way from front to back.
   typedef struct packed {
      logic [1:0]             num_m1;
      logic [3:0][WORD_W-1:0] words;
      logic                   mark_last;
   } drain_type;

   typedef struct packed {
      logic            hit;
      logic [OP_W-1:0] fused_op;
      logic [1:0]      slot;
   } fuse_type;

   // Pair table: newcomer kind (one or two words), newcomer opcode, held opcode.
   function automatic fuse_type fuse_lookup(input logic two_word,
                                            input logic [OP_W-1:0] new_op,
                                            input logic [OP_W-1:0] held_op);
      fuse_type r;
      r = '0;
      if (!two_word) begin
         if (new_op == OP_PUSH) begin
            case (held_op)
               OP_NUMBER_ADD:   r = '{1'b1, OP_NUMBER_ADD_PUSH, 2'd0};
               OP_NUMBER_SUB:   r = '{1'b1, OP_NUMBER_SUB_PUSH, 2'd0};
               OP_CAR:          r = '{1'b1, OP_CAR_PUSH, 2'd0};
               OP_CDR:          r = '{1'b1, OP_CDR_PUSH, 2'd0};
               OP_CONSTANT:     r = '{1'b1, OP_CONSTANT_PUSH, 2'd0};
               OP_REFER_LOCAL:  r = '{1'b1, OP_REFER_LOCAL_PUSH, 2'd0};
               OP_REFER_GLOBAL: r = '{1'b1, OP_REFER_GLOBAL_PUSH, 2'd0};
               OP_REFER_FREE:   r = '{1'b1, OP_REFER_FREE_PUSH, 2'd0};
               default:         r = '0;
            endcase
         end
      end else begin
         case (new_op)
            OP_TEST: begin
               if (held_op == OP_NOT) r = '{1'b1, OP_NOT_TEST, 2'd1};
            end
            OP_BR_NOT_NULL: begin
               if (held_op == OP_REFER_LOCAL) r = '{1'b1, OP_RL_BR_NOT_NULL, 2'd2};
            end
            OP_BR_NOT_LT: begin
               if (held_op == OP_REFER_LOCAL) r = '{1'b1, OP_RL_BR_NOT_LT, 2'd2};
            end
            OP_BR_NOT_LE: begin
               if (held_op == OP_RL_PUSH_CONSTANT) r = '{1'b1, OP_RLPC_BR_NOT_LE, 2'd3};
            end
            OP_BR_NOT_NUM_EQ: begin
               if (held_op == OP_RL_PUSH_CONSTANT)
                  r = '{1'b1, OP_RLPC_BR_NOT_NUM_EQ, 2'd3};
            end
            OP_BR_NOT_GE: begin
               if (held_op == OP_RL_PUSH_CONSTANT) r = '{1'b1, OP_RLPC_BR_NOT_GE, 2'd3};
            end
            OP_FRAME: begin
               if (held_op == OP_PUSH) r = '{1'b1, OP_PUSH_FRAME, 2'd1};
            end
            OP_ENTER: begin
               if (held_op == OP_PUSH) r = '{1'b1, OP_PUSH_ENTER, 2'd1};
            end
            OP_CONSTANT: begin
               if (held_op == OP_REFER_LOCAL_PUSH) r = '{1'b1, OP_RL_PUSH_CONSTANT, 2'd2};
               else if (held_op == OP_PUSH) r = '{1'b1, OP_PUSH_CONSTANT, 2'd1};
            end
            OP_CALL: begin
               case (held_op)
                  OP_REFER_GLOBAL: r = '{1'b1, OP_REFER_GLOBAL_CALL, 2'd2};
                  OP_REFER_LOCAL:  r = '{1'b1, OP_REFER_LOCAL_CALL, 2'd2};
                  OP_REFER_FREE:   r = '{1'b1, OP_REFER_FREE_CALL, 2'd2};
                  OP_SHIFT:        r = '{1'b1, OP_SHIFT_CALL, 2'd3};
                  default:         r = '0;
               endcase
            end
            default: r = '0;
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/bpf_stream_if.sv]
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface bpf_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/bpf_front.sv]
// Front end: holding slot, pair fusion and drain requests.
`default_nettype none
module bpf_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bpf_stream_if.sink                req_if,
   output logic                      push_valid,
   output bpf_pkg::drain_type        push_entry,
   input  wire logic                 push_ready
);
   import bpf_pkg::*;

   logic [2:0]        held_kind_ff, held_kind_in;
   logic [WORD_W-1:0] held_instr_ff, held_instr_in;
   logic [WORD_W-1:0] held_one_ff, held_one_in;
   logic [WORD_W-1:0] held_two_ff, held_two_in;
   logic [WORD_W-1:0] held_three_ff, held_three_in;

   req_payload_type req;
   fuse_type        rule;
   logic            accept;
   logic            held_full;
   logic            held_instr_kind;
   logic            new_fusable;
   logic            do_fuse;

   assign req    = req_if.payload;
   assign accept = req_if.valid && push_ready;
   assign req_if.ready = push_ready;

   assign held_full       = (held_kind_ff <= KIND_FOUR);
   assign held_instr_kind = held_full && (held_kind_ff != KIND_EXTRA);
   assign new_fusable     = (req.kind == KIND_ONE || req.kind == KIND_TWO)
                            && (req.instr_word[WORD_W-1:OP_W] == '0)
                            && (held_instr_ff[WORD_W-1:OP_W] == '0);

   assign rule = fuse_lookup(req.kind == KIND_TWO, req.instr_word[OP_W-1:0],
                             held_instr_ff[OP_W-1:0]);
   assign do_fuse = (req.cmd == CMD_PUT) && held_instr_kind && new_fusable && rule.hit;

   // Drain the held packet on end or on any put that does not fuse.
   always_comb begin
      push_valid           = req_if.valid && held_full && !do_fuse;
      push_entry.num_m1    = (held_kind_ff == KIND_EXTRA) ? 2'd0 : 2'(held_kind_ff - 3'd1);
      push_entry.words     = {held_three_ff, held_two_ff, held_one_ff, held_instr_ff};
      push_entry.mark_last = (req.cmd == CMD_END);
   end

   always_comb begin
      held_kind_in  = held_kind_ff;
      held_instr_in = held_instr_ff;
      held_one_in   = held_one_ff;
      held_two_in   = held_two_ff;
      held_three_in = held_three_ff;
      if (accept) begin
         if (req.cmd == CMD_END) begin
            held_kind_in = KIND_EMPTY;
         end else if (do_fuse) begin
            held_instr_in = {{(WORD_W-OP_W){1'b0}}, rule.fused_op};
            case (rule.slot)
               2'd1:    held_one_in   = req.arg_one;
               2'd2:    held_two_in   = req.arg_one;
               2'd3:    held_three_in = req.arg_one;
               default: held_one_in   = held_one_ff;
            endcase
            if (rule.slot != 2'd0) held_kind_in = {1'b0, rule.slot} + 3'd1;
         end else if (req.kind <= KIND_FOUR) begin
            held_kind_in  = req.kind;
            held_instr_in = req.instr_word;
            held_one_in   = req.arg_one;
            held_two_in   = req.arg_two;
            held_three_in = req.arg_three;
         end else begin
            held_kind_in = KIND_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_kind_ff <= KIND_EMPTY;
      end else begin
         held_kind_ff <= held_kind_in;
      end
      held_instr_ff <= held_instr_in;
      held_one_ff   <= held_one_in;
      held_two_ff   <= held_two_in;
      held_three_ff <= held_three_in;
   end

endmodule
`default_nettype wire

[rtl/core/bpf_queue.sv]
// Small FIFO of drained packets between front and back.
`default_nettype none
module bpf_queue #(
   parameter int Depth = bpf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire bpf_pkg::drain_type  push_entry,
   output logic                     push_ready,
   output logic                     head_valid,
   output bpf_pkg::drain_type       head_entry,
   input  wire logic                pop
);
   import bpf_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   drain_type       entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop) count_in = count_ff + CntW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

[rtl/core/bpf_back.sv]
// Back end: serialize a drained packet into code words behind an output register.
`default_nettype none
module bpf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire bpf_pkg::drain_type  head_entry,
   output logic                     pop,
   bpf_stream_if.source             rsp_if
);
   import bpf_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic [1:0]      index_ff, index_in;
   logic            load;
   logic            final_word;

   assign load       = head_valid && (!out_valid_ff || rsp_if.ready);
   assign final_word = (index_ff == head_entry.num_m1);
   assign pop        = load && final_word;

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      index_in     = index_ff;
      if (load) begin
         out_valid_in          = 1'b1;
         out_data_in.code_word = head_entry.words[index_ff];
         out_data_in.last_word = head_entry.mark_last && final_word;
         index_in              = final_word ? 2'd0 : index_ff + 2'd1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         index_ff     <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
      end
      out_data_ff <= out_data_in;
   end

endmodule
`default_nettype wire

[rtl/core/bytecode_pair_fusion.sv]
// Top level of bytecode pair fusion: front end, drain queue and word serializer.
//
//   channel   direction  payload                                           handshake
//   req_if    in         cmd, kind, instr_word, arg_one/two/three          valid/ready
//   rsp_if    out        code_word, last_word                              valid/ready
//
// A put or end item is taken on a valid/ready handshake; fusion decides against
// the held packet in the same cycle, so items may arrive every cycle while the
// drain queue has room. A drained packet leaves as 1 to 4 code words, one word
// per cycle while rsp_if.ready allows; the output serializer sets the sustained rate.
// req_if.ready drops only while the drain queue (QUEUE_DEPTH entries) is full.
// Synchronous reset empties the holding slot, the queue and the output register.
`default_nettype none
module bytecode_pair_fusion #(
   parameter int QUEUE_DEPTH = bpf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   bpf_stream_if.sink    req_if,
   bpf_stream_if.source  rsp_if
);
   import bpf_pkg::*;

   // front -> queue
   logic      push_valid;
   logic      push_ready;
   drain_type push_entry;

   // queue -> back
   logic      head_valid;
   drain_type head_entry;
   logic      pop;

   // Hold one packet, fuse listed pairs, request drains.
   bpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Decouple the front from output stalls.
   bpf_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // Advance through the words of the head packet, one per cycle while rsp_if accepts.
   bpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire

[test/bytecode_pair_fusion_tb.sv]
// Self-checking testbench for bytecode pair fusion: scoreboard class, stream drivers, stimulus.
`timescale 1ns / 1ps
module bytecode_pair_fusion_tb;
   import bpf_pkg::*;

   // Kinds the package does not name: three-word packets and unknown puts.
   localparam logic [2:0] KIND_THREE    = 3'd3;
   localparam logic [2:0] KIND_BAD_FIVE = 3'd5;
   localparam logic [2:0] KIND_BAD_SIX  = 3'd6;

   localparam int RANDOM_ITEMS = 380;
   localparam int HOLD_OFF_CYCLES = 64;

   // One entry of the pair list: newcomer kind and opcode, held opcode, fused result.
   typedef struct packed {
      logic [2:0]      new_kind;
      logic [OP_W-1:0] new_op;
      logic [OP_W-1:0] held_op;
      logic [OP_W-1:0] fused_op;
      logic [1:0]      slot;
   } pair_rule_type;

   // Predicts the code words from the accepted items and checks them in order.
   class fusion_scoreboard;
      pair_rule_type     pair_list[$];
      logic [2:0]        held_kind;
      logic [WORD_W-1:0] held_instr;
      logic [WORD_W-1:0] held_arg_one;
      logic [WORD_W-1:0] held_arg_two;
      logic [WORD_W-1:0] held_arg_three;
      rsp_payload_type   expected_words[$];
      int                errors;
      int                items_seen;
      int                words_checked;
      int                fusions;
      int                end_drains;

      function new();
         held_kind      = KIND_EMPTY;
         held_instr     = '0;
         held_arg_one   = '0;
         held_arg_two   = '0;
         held_arg_three = '0;
         errors         = 0;
         items_seen     = 0;
         words_checked  = 0;
         fusions        = 0;
         end_drains     = 0;
         add_rule(KIND_ONE, OP_PUSH, OP_NUMBER_ADD, OP_NUMBER_ADD_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_NUMBER_SUB, OP_NUMBER_SUB_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_CAR, OP_CAR_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_CDR, OP_CDR_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_CONSTANT, OP_CONSTANT_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_REFER_LOCAL, OP_REFER_LOCAL_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_REFER_GLOBAL, OP_REFER_GLOBAL_PUSH, 2'd0);
         add_rule(KIND_ONE, OP_PUSH, OP_REFER_FREE, OP_REFER_FREE_PUSH, 2'd0);
         add_rule(KIND_TWO, OP_TEST, OP_NOT, OP_NOT_TEST, 2'd1);
         add_rule(KIND_TWO, OP_BR_NOT_NULL, OP_REFER_LOCAL, OP_RL_BR_NOT_NULL, 2'd2);
         add_rule(KIND_TWO, OP_BR_NOT_LT, OP_REFER_LOCAL, OP_RL_BR_NOT_LT, 2'd2);
         add_rule(KIND_TWO, OP_BR_NOT_LE, OP_RL_PUSH_CONSTANT, OP_RLPC_BR_NOT_LE, 2'd3);
         add_rule(KIND_TWO, OP_BR_NOT_NUM_EQ, OP_RL_PUSH_CONSTANT, OP_RLPC_BR_NOT_NUM_EQ,
                  2'd3);
         add_rule(KIND_TWO, OP_BR_NOT_GE, OP_RL_PUSH_CONSTANT, OP_RLPC_BR_NOT_GE, 2'd3);
         add_rule(KIND_TWO, OP_FRAME, OP_PUSH, OP_PUSH_FRAME, 2'd1);
         add_rule(KIND_TWO, OP_ENTER, OP_PUSH, OP_PUSH_ENTER, 2'd1);
         add_rule(KIND_TWO, OP_CONSTANT, OP_REFER_LOCAL_PUSH, OP_RL_PUSH_CONSTANT, 2'd2);
         add_rule(KIND_TWO, OP_CONSTANT, OP_PUSH, OP_PUSH_CONSTANT, 2'd1);
         add_rule(KIND_TWO, OP_CALL, OP_REFER_GLOBAL, OP_REFER_GLOBAL_CALL, 2'd2);
         add_rule(KIND_TWO, OP_CALL, OP_REFER_LOCAL, OP_REFER_LOCAL_CALL, 2'd2);
         add_rule(KIND_TWO, OP_CALL, OP_REFER_FREE, OP_REFER_FREE_CALL, 2'd2);
         add_rule(KIND_TWO, OP_CALL, OP_SHIFT, OP_SHIFT_CALL, 2'd3);
      endfunction

      function void add_rule(logic [2:0] nk, logic [OP_W-1:0] nop, logic [OP_W-1:0] hop,
                             logic [OP_W-1:0] fop, logic [1:0] sl);
         pair_rule_type r;
         r.new_kind = nk;
         r.new_op   = nop;
         r.held_op  = hop;
         r.fused_op = fop;
         r.slot     = sl;
         pair_list = {pair_list, r};
      endfunction

      function bit holds_instruction();
         return held_kind >= KIND_ONE && held_kind <= KIND_FOUR;
      endfunction

      // Index of the pair that the held packet and the newcomer form, or -1.
      function int find_pair(logic [2:0] kind, logic [WORD_W-1:0] op);
         for (int i = 0; i < pair_list.size(); i++) begin
            if (pair_list[i].new_kind == kind &&
                op == {{(WORD_W-OP_W){1'b0}}, pair_list[i].new_op} &&
                held_instr == {{(WORD_W-OP_W){1'b0}}, pair_list[i].held_op})
               return i;
         end
         return -1;
      endfunction

      // Random pair whose held opcode matches the held packet, or -1 if none.
      function int pick_partner();
         int hits[$];
         if (!holds_instruction())
            return -1;
         for (int i = 0; i < pair_list.size(); i++) begin
            if (held_instr == {{(WORD_W-OP_W){1'b0}}, pair_list[i].held_op})
               hits = {hits, i};
         end
         if (hits.size() == 0)
            return -1;
         return hits[$urandom_range(0, hits.size() - 1)];
      endfunction

      // Queue the held packet's words and empty the slot.
      function void drain_held(bit mark_last);
         logic [WORD_W-1:0] words[4];
         rsp_payload_type   w;
         int                n;
         if (held_kind <= KIND_FOUR) begin
            words[0] = held_instr;
            words[1] = held_arg_one;
            words[2] = held_arg_two;
            words[3] = held_arg_three;
            n = (held_kind == KIND_EXTRA) ? 1 : int'(held_kind);
            for (int i = 0; i < n; i++) begin
               w.code_word = words[i];
               w.last_word = mark_last && (i == n - 1);
               expected_words = {expected_words, w};
            end
         end
         held_kind = KIND_EMPTY;
      endfunction

      function void note_item(req_payload_type p);
         int idx;
         items_seen++;
         if (p.cmd == CMD_END) begin
            end_drains++;
            drain_held(1'b1);
            return;
         end
         // Only one- and two-word newcomers against a held instruction can fuse.
         if (holds_instruction() && (p.kind == KIND_ONE || p.kind == KIND_TWO)) begin
            idx = find_pair(p.kind, p.instr_word);
            if (idx >= 0) begin
               fusions++;
               held_instr = {{(WORD_W-OP_W){1'b0}}, pair_list[idx].fused_op};
               case (pair_list[idx].slot)
                  2'd1:    held_arg_one   = p.arg_one;
                  2'd2:    held_arg_two   = p.arg_one;
                  2'd3:    held_arg_three = p.arg_one;
                  default: ;
               endcase
               if (pair_list[idx].slot != 2'd0)
                  held_kind = 3'(pair_list[idx].slot) + 3'd1;
               return;
            end
         end
         drain_held(1'b0);
         // An unknown kind leaves the slot empty and drops the packet.
         if (p.kind <= KIND_FOUR) begin
            held_kind      = p.kind;
            held_instr     = p.instr_word;
            held_arg_one   = p.arg_one;
            held_arg_two   = p.arg_two;
            held_arg_three = p.arg_three;
         end
      endfunction

      function void check_word(rsp_payload_type got);
         rsp_payload_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected code word, expected none, actual %h last_word %b",
                     $time, got.code_word, got.last_word);
            return;
         end
         want = expected_words.pop_front();
         if (got.code_word !== want.code_word) begin
            errors++;
            $display("%0t: code_word mismatch, expected %h, actual %h", $time,
                     want.code_word, got.code_word);
         end
         if (got.last_word !== want.last_word) begin
            errors++;
            $display("%0t: last_word mismatch, expected %b, actual %b", $time,
                     want.last_word, got.last_word);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Shared between the two drivers: idle bursts allowed, and a pending long hold-off.
   bit idle_enable = 1'b1;
   bit stall_request = 1'b0;

   fusion_scoreboard sb;

   bpf_stream_if #(.payload_type(req_payload_type)) req_if ();
   bpf_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   bytecode_pair_fusion u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Give up well past the slowest correct run.
   initial begin : watchdog
      #400000;
      $display("FAIL bytecode_pair_fusion");
      $finish;
   end

   // Mostly random words, with the all-zero and all-one extremes mixed in.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_payload_type put_pkt(logic [2:0] kind, logic [WORD_W-1:0] op,
                                               logic [WORD_W-1:0] a1,
                                               logic [WORD_W-1:0] a2,
                                               logic [WORD_W-1:0] a3);
      req_payload_type p;
      p.cmd        = CMD_PUT;
      p.kind       = kind;
      p.instr_word = op;
      p.arg_one    = a1;
      p.arg_two    = a2;
      p.arg_three  = a3;
      return p;
   endfunction

   // End command; kind and word fields carry junk that the block must ignore.
   function automatic req_payload_type end_pkt(logic [2:0] kind, logic [WORD_W-1:0] junk);
      req_payload_type p;
      p = put_pkt(kind, junk, ~junk, junk, ~junk);
      p.cmd = CMD_END;
      return p;
   endfunction

   function automatic logic [WORD_W-1:0] op_word(logic [OP_W-1:0] op);
      return {{(WORD_W-OP_W){1'b0}}, op};
   endfunction

   // Mostly well-formed chains: follow the held packet with a partner that fuses,
   // or start a new packet that some pair can extend. The rest is noise.
   function automatic req_payload_type random_item();
      req_payload_type p;
      pair_rule_type   r;
      int              pick;
      int              idx;
      pick = $urandom_range(0, 99);
      idx  = sb.pick_partner();
      p = put_pkt(3'($urandom_range(1, 2)), rand_word(), rand_word(), rand_word(),
                  rand_word());
      if (pick < 7) begin
         p = end_pkt(3'($urandom_range(0, 7)), rand_word());
      end else if (pick < 55 && idx >= 0) begin
         r = sb.pair_list[idx];
         p.kind       = r.new_kind;
         p.instr_word = op_word(r.new_op);
      end else if (pick < 85) begin
         r = sb.pair_list[$urandom_range(0, sb.pair_list.size() - 1)];
         p.kind       = 3'($urandom_range(1, 4));
         p.instr_word = op_word(($urandom_range(0, 3) == 0) ? r.new_op : r.held_op);
      end else begin
         p.kind = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 2))
            0:       p.instr_word = op_word(OP_W'($urandom_range(0, 63)));
            1:       p.instr_word = op_word(OP_W'($urandom_range(0, 41))) |
                                    (64'd1 << $urandom_range(OP_W, WORD_W - 1));
            default: p.instr_word = rand_word();
         endcase
      end
      return p;
   endfunction

   // Offer one item, with an occasional idle burst first; return once it is taken.
   task automatic send_item(input req_payload_type p);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      // Sample right after the edge: the block's own updates are not yet visible.
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_item(p);
   endtask

   // Result side: take words, stall in short bursts, and honor a long hold-off.
   initial begin : word_sink
      int gap;
      int hold;
      gap  = 0;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_word(rsp_if.payload);
         if (stall_request) begin
            stall_request = 1'b0;
            hold = HOLD_OFF_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_if.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // End on an empty slot: no words, junk fields ignored.
      send_item(end_pkt(KIND_EMPTY, '1));
      // Held extra word whose data equals an opcode must not fuse with a push.
      send_item(put_pkt(KIND_EXTRA, op_word(OP_NUMBER_ADD), '1, '1, '1));
      send_item(put_pkt(KIND_ONE, op_word(OP_PUSH), '0, '0, '0));
      send_item(put_pkt(KIND_TWO, op_word(OP_FRAME), '1, '0, '0));
      // Chain three fusions on a four-word held packet; rename keeps the old args.
      send_item(put_pkt(KIND_FOUR, op_word(OP_REFER_LOCAL), 64'h0123_4567_89ab_cdef,
                        64'hfedc_ba98_7654_3210, 64'h5555_aaaa_5555_aaaa));
      send_item(put_pkt(KIND_ONE, op_word(OP_PUSH), '1, '1, '1));
      send_item(put_pkt(KIND_TWO, op_word(OP_CONSTANT), 64'h8000_0000_0000_0001, '1, '1));
      send_item(put_pkt(KIND_TWO, op_word(OP_BR_NOT_GE), '1, '0, '0));
      send_item(end_pkt(KIND_ONE, '0));
      // Three-word newcomer never fuses.
      send_item(put_pkt(KIND_THREE, op_word(OP_REFER_GLOBAL), '1, '0, '1));
      send_item(put_pkt(KIND_THREE, op_word(OP_CALL), '0, '1, '0));
      // Upper opcode bits set: no match even though the low bits say call.
      send_item(put_pkt(KIND_ONE, op_word(OP_SHIFT), '0, '0, '0));
      send_item(put_pkt(KIND_TWO, op_word(OP_CALL) | 64'h8000_0000_0000_0000, '1, '1, '1));
      // Unknown kinds drain the held packet and leave the slot empty.
      send_item(put_pkt(KIND_BAD_SIX, '1, '1, '1, '1));
      send_item(put_pkt(KIND_ONE, op_word(OP_PUSH), '1, '1, '1));
      send_item(put_pkt(KIND_BAD_FIVE, '0, '0, '0, '0));
      send_item(put_pkt(KIND_EMPTY, op_word(OP_PUSH), '1, '1, '1));
      send_item(put_pkt(KIND_ONE, op_word(OP_NOT), '1, '1, '1));
      send_item(put_pkt(KIND_TWO, op_word(OP_TEST), '1, '0, '0));
      send_item(put_pkt(KIND_EXTRA, '1, '0, '0, '0));
      send_item(end_pkt(KIND_BAD_FIVE, '1));
      send_item(end_pkt(KIND_FOUR, '1));
      send_item(put_pkt(KIND_FOUR, '1, '1, '1, '1));
      send_item(end_pkt(KIND_TWO, 64'h0f0f_0f0f_0f0f_0f0f));

      // Random part: one long result-side hold-off, then quiet handshakes at the end.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3)
            stall_request = 1'b1;
         if (i == RANDOM_ITEMS - 60)
            idle_enable = 1'b0;
         send_item(random_item());
      end
      send_item(end_pkt(KIND_EXTRA, '0));
      req_if.valid <= 1'b0;

      // Drain, then watch a while longer for stray words.
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d items: %0d fused pairs, %0d end commands, %0d code words checked.",
               sb.items_seen, sb.fusions, sb.end_drains, sb.words_checked);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("PASS bytecode_pair_fusion");
      end else begin
         $display("FAIL bytecode_pair_fusion");
      end
      $finish;
   end

endmodule

[bytecode_pair_fusion.f]
rtl/core/bpf_pkg.sv
rtl/core/bpf_stream_if.sv
rtl/core/bpf_front.sv
rtl/core/bpf_queue.sv
rtl/core/bpf_back.sv
rtl/core/bytecode_pair_fusion.sv
test/bytecode_pair_fusion_tb.sv
